// ----- rtl/core/tbr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared codes and controller/datapath interface types for the triangle
// bounding-box rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

    // func field codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // setup product select / accumulate codes
    typedef logic [2:0] tbr_sel_t;

    localparam tbr_sel_t SEL_AREA_ADD = 3'd0;  // (bx-ax)*(cy-ay) into area
    localparam tbr_sel_t SEL_AREA_SUB = 3'd1;  // (by-ay)*(cx-ax) out of area
    localparam tbr_sel_t SEL_KN_X     = 3'd2;  // (cy-ay)*(x0-ax) into k edge
    localparam tbr_sel_t SEL_KN_Y     = 3'd3;  // (ax-cx)*(y0-ay) into k edge
    localparam tbr_sel_t SEL_LN_X     = 3'd4;  // (ay-by)*(x0-ax) into l edge
    localparam tbr_sel_t SEL_LN_Y     = 3'd5;  // (bx-ax)*(y0-ay) into l edge
    localparam tbr_sel_t SEL_DRAIN    = 3'd6;  // last count: drain only

    typedef struct packed {
        logic     load;     // latch vertices and colour
        logic     box;      // bounding box, differences, clear accumulators
        logic     mul_en;   // issue one setup product
        logic     acc_en;   // accumulate the previous product
        tbr_sel_t mul_sel;
        tbr_sel_t acc_sel;
        logic     fin;      // finish setup, prime the walk
        logic     step;     // test current point, emit it, advance
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;     // result register can take a new point
        logic last_pt;      // current point is the final one of the box
        logic empty;        // no integer column in the box
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/tbr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_ctrl
// Sequencer: input handshake, triangle setup steps and the scan walk state.
// ----------------------------------------------------------------------------
module tbr_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic             func,
    output tbr_pkg::dp_cmd_t      cmd,
    input  wire tbr_pkg::dp_sts_t sts
);
    import tbr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BOX  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;

    logic [2:0] state_reg, state_next;
    tbr_sel_t   cnt_reg, cnt_next;
    logic       accept;

    assign item_ready = ((state_reg == ST_IDLE) || (state_reg == ST_RUN)) && sts.out_free;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept && (func == FUNC_LOAD);
        cmd.step    = accept && (func == FUNC_STEP) && (state_reg == ST_RUN);
        cmd.box     = (state_reg == ST_BOX);
        cmd.mul_en  = (state_reg == ST_MUL) && (cnt_reg != SEL_DRAIN);
        cmd.acc_en  = (state_reg == ST_MUL) && (cnt_reg != SEL_AREA_ADD);
        cmd.mul_sel = cnt_reg;
        cmd.acc_sel = cnt_reg - 3'd1;
        cmd.fin     = (state_reg == ST_FIN);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_BOX;
            end
            ST_RUN:
            begin
                if (cmd.load)
                    state_next = ST_BOX;
                else if (cmd.step && sts.last_pt)
                    state_next = ST_IDLE;
            end
            ST_BOX:
            begin
                state_next = ST_MUL;
                cnt_next   = SEL_AREA_ADD;
            end
            ST_MUL:
            begin
                if (cnt_reg == SEL_DRAIN)
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            ST_FIN:
            begin
                state_next = sts.empty ? ST_IDLE : ST_RUN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= SEL_AREA_ADD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // final point of the box ends the walk
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.last_pt && !cmd.load) |=> (state_reg == ST_IDLE))
        else $error("walk did not end after last point");

    // a load shuts the input until setup is done
    a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!item_ready && (state_reg == ST_BOX)))
        else $error("input open during setup");

    // setup count never runs past the drain slot
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg <= SEL_DRAIN))
        else $error("setup count out of range");

    // steps only emit while a triangle is active
    a_step_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((state_reg == ST_RUN) && !cmd.load))
        else $error("step emitted outside walk");

endmodule
`default_nettype wire

// ----- rtl/core/tbr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_datapath
// Vertex store, setup multiplier and accumulators, incremental edge walk
// and result register.
// ----------------------------------------------------------------------------
module tbr_datapath
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tbr_pkg::dp_cmd_t              cmd,
    output tbr_pkg::dp_sts_t                   sts,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic        [31:0]            paint,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [11:0]                 pix_x,
    output logic signed [11:0]                 pix_y,
    output logic                               covered,
    output logic        [31:0]                 shade,
    output logic                               last
);
    import tbr_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W + 2;   // setup product
    localparam int EW = 2 * W + 4;   // edge values and area
    localparam logic [W-1:0] FMASK = W'((1 << F) - 1);

    function automatic logic signed [W-1:0] min3(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [W-1:0] c);
        logic signed [W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [W-1:0] max3(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [W-1:0] c);
        logic signed [W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // divide by one pixel, rounding toward zero
    function automatic logic signed [W-1:0] trunc_px(input logic signed [W-1:0] v);
        logic signed [W-1:0] q;
        q = v >>> F;
        if (v[W-1] && (|(v & FMASK)))
            q = q + W'(1);
        return q;
    endfunction

    // vertex store
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic        [31:0]  fill_reg;

    // box
    logic signed [W-1:0] xmin_c, ymin_c, rs_c;
    logic signed [W-1:0] row_start_reg, x0_reg, y0_reg, limit_x_reg, limit_y_reg;
    logic signed [W-1:0] scan_x_reg, scan_y_reg;

    // vertex differences
    logic signed [W:0] d_bax_reg, d_cay_reg, d_bay_reg, d_cax_reg, d_acx_reg, d_aby_reg;
    logic signed [W:0] dx0a_reg, dy0a_reg;

    // setup products
    logic signed [W:0]    mul_a, mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [EW-1:0] prod_ext;

    // edge values
    logic signed [EW-1:0] area_reg, kn_row_reg, ln_row_reg, rn_row_reg;
    logic signed [EW-1:0] kn_reg, ln_reg, rn_reg;
    logic signed [EW-1:0] dkx_reg, dlx_reg, drx_reg, dky_reg, dly_reg, dry_reg;
    logic signed [EW-1:0] dkx_c, dlx_c, dky_c, dly_c;
    logic                 area_pos_reg, area_neg_reg;

    // walk
    logic signed [W+1:0]  sx_inc, nx_c, sy_inc;
    logic                 xend, yend, fin_pt;
    logic                 k_pos, l_pos, r_pos, k_neg, l_neg, r_neg, cov_c;
    logic signed [W+11:0] px_ext, py_ext;

    logic result_valid_reg;

    assign xmin_c = min3(ax_reg, bx_reg, cx_reg);
    assign ymin_c = min3(ay_reg, by_reg, cy_reg);
    assign rs_c   = trunc_px(xmin_c);

    assign dkx_c = EW'(d_cay_reg) <<< F;
    assign dlx_c = EW'(d_aby_reg) <<< F;
    assign dky_c = EW'(d_acx_reg) <<< F;
    assign dly_c = EW'(d_bax_reg) <<< F;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            bx_reg   <= bx;
            by_reg   <= by;
            cx_reg   <= cx;
            cy_reg   <= cy;
            fill_reg <= paint;
        end
    end

    // operand select for the shared setup multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            SEL_AREA_ADD: begin mul_a = d_bax_reg; mul_b = d_cay_reg; end
            SEL_AREA_SUB: begin mul_a = d_bay_reg; mul_b = d_cax_reg; end
            SEL_KN_X:     begin mul_a = d_cay_reg; mul_b = dx0a_reg;  end
            SEL_KN_Y:     begin mul_a = d_acx_reg; mul_b = dy0a_reg;  end
            SEL_LN_X:     begin mul_a = d_aby_reg; mul_b = dx0a_reg;  end
            SEL_LN_Y:     begin mul_a = d_bax_reg; mul_b = dy0a_reg;  end
            default:      begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    assign prod_ext = EW'(prod_reg);

    // walk arithmetic
    assign sx_inc = (W+2)'(scan_x_reg) + (W+2)'(1);
    assign nx_c   = sx_inc <<< F;
    assign sy_inc = (W+2)'(scan_y_reg) + ((W+2)'(1) <<< F);
    assign xend   = nx_c > (W+2)'(limit_x_reg);
    assign yend   = sy_inc > (W+2)'(limit_y_reg);
    assign fin_pt = xend && yend;

    assign k_pos = !kn_reg[EW-1] && (|kn_reg);
    assign l_pos = !ln_reg[EW-1] && (|ln_reg);
    assign r_pos = !rn_reg[EW-1] && (|rn_reg);
    assign k_neg = kn_reg[EW-1];
    assign l_neg = ln_reg[EW-1];
    assign r_neg = rn_reg[EW-1];
    assign cov_c = (area_pos_reg && k_pos && l_pos && r_pos) ||
                   (area_neg_reg && k_neg && l_neg && r_neg);

    assign px_ext = (W+12)'(scan_x_reg);
    assign py_ext = (W+12)'(trunc_px(scan_y_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.box)
        begin
            row_start_reg <= rs_c;
            x0_reg        <= rs_c <<< F;
            y0_reg        <= ymin_c;
            limit_x_reg   <= max3(ax_reg, bx_reg, cx_reg);
            limit_y_reg   <= max3(ay_reg, by_reg, cy_reg);
            d_bax_reg     <= (W+1)'(bx_reg) - (W+1)'(ax_reg);
            d_cay_reg     <= (W+1)'(cy_reg) - (W+1)'(ay_reg);
            d_bay_reg     <= (W+1)'(by_reg) - (W+1)'(ay_reg);
            d_cax_reg     <= (W+1)'(cx_reg) - (W+1)'(ax_reg);
            d_acx_reg     <= (W+1)'(ax_reg) - (W+1)'(cx_reg);
            d_aby_reg     <= (W+1)'(ay_reg) - (W+1)'(by_reg);
            area_reg      <= '0;
            kn_row_reg    <= '0;
            ln_row_reg    <= '0;
        end
        else if (cmd.acc_en)
        begin
            case (cmd.acc_sel)
                SEL_AREA_ADD: area_reg   <= area_reg + prod_ext;
                SEL_AREA_SUB: area_reg   <= area_reg - prod_ext;
                SEL_KN_X,
                SEL_KN_Y:     kn_row_reg <= kn_row_reg + prod_ext;
                SEL_LN_X,
                SEL_LN_Y:     ln_row_reg <= ln_row_reg + prod_ext;
                default:      area_reg   <= area_reg;
            endcase
        end
        else if (cmd.fin)
        begin
            kn_reg       <= kn_row_reg;
            ln_reg       <= ln_row_reg;
            rn_reg       <= area_reg - kn_row_reg - ln_row_reg;
            rn_row_reg   <= area_reg - kn_row_reg - ln_row_reg;
            dkx_reg      <= dkx_c;
            dlx_reg      <= dlx_c;
            dky_reg      <= dky_c;
            dly_reg      <= dly_c;
            drx_reg      <= -(dkx_c + dlx_c);
            dry_reg      <= -(dky_c + dly_c);
            area_pos_reg <= !area_reg[EW-1] && (|area_reg);
            area_neg_reg <= area_reg[EW-1];
            scan_x_reg   <= row_start_reg;
            scan_y_reg   <= y0_reg;
        end
        else if (cmd.step && !fin_pt)
        begin
            if (!xend)
            begin
                scan_x_reg <= scan_x_reg + W'(1);
                kn_reg     <= kn_reg + dkx_reg;
                ln_reg     <= ln_reg + dlx_reg;
                rn_reg     <= rn_reg + drx_reg;
            end
            else
            begin
                scan_x_reg <= row_start_reg;
                scan_y_reg <= sy_inc[W-1:0];
                kn_row_reg <= kn_row_reg + dky_reg;
                ln_row_reg <= ln_row_reg + dly_reg;
                rn_row_reg <= rn_row_reg + dry_reg;
                kn_reg     <= kn_row_reg + dky_reg;
                ln_reg     <= ln_row_reg + dly_reg;
                rn_reg     <= rn_row_reg + dry_reg;
            end
        end
    end

    // setup multiplier, one product a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            dx0a_reg <= (W+1)'(x0_reg) - (W+1)'(ax_reg);
            dy0a_reg <= (W+1)'(y0_reg) - (W+1)'(ay_reg);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            pix_x   <= px_ext[11:0];
            pix_y   <= py_ext[11:0];
            covered <= cov_c;
            shade   <= fill_reg;
            last    <= fin_pt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.step)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign sts.out_free = !result_valid_reg || result_ready;
    assign sts.last_pt  = fin_pt;
    assign sts.empty    = x0_reg > limit_x_reg;

endmodule
`default_nettype wire

// ----- rtl/core/triangle_bbox_rasterizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer
// Scans the bounding box of a fixed-point triangle and flags covered points.
// ----------------------------------------------------------------------------
// A load transfer (func = 0) takes three signed fixed-point vertices and a
// colour and occupies the block for the accept, a bounding-box step, six
// products of area and starting edge values on the single shared setup
// multiplier plus one drain, and a step that primes the walk. After that
// each step transfer (func = 1) is taken one per cycle unless the output
// stalls: the edge values are kept incrementally, so a step is only adds and
// sign tests, and the registered result stage takes a new step in the same
// cycle that the waiting point transfers out. Points run row by row from the
// fractional ymin and from xmin rounded toward zero; a point is covered when
// both edge weights and their remainder are strictly inside, tested by sign
// against twice the area, and a zero-area triangle covers nothing. The point
// flagged last ends the triangle. Steps with no active triangle are taken
// and dropped, and a load always replaces the active triangle.
// ----------------------------------------------------------------------------
module triangle_bbox_rasterizer
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic                          func,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic        [31:0]            paint,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [11:0]                 pix_x,
    output logic signed [11:0]                 pix_y,
    output logic                               covered,
    output logic        [31:0]                 shade,
    output logic                               last
);
    import tbr_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    tbr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .cmd        (cmd),
        .sts        (sts)
    );

    tbr_datapath
    #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .ax           (ax),
        .ay           (ay),
        .bx           (bx),
        .by           (by),
        .cx           (cx),
        .cy           (cy),
        .paint        (paint),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .covered      (covered),
        .shade        (shade),
        .last         (last)
    );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle bounding-box rasterizer.
// ----------------------------------------------------------------------------
// Triangles are loaded and their bounding boxes walked one step transfer at a
// time. A local scan model follows every accepted transfer and queues the
// point it expects. A checker compares each result transfer field by field
// against the oldest queued point. Directed tests cover corner coordinates,
// steps with no active triangle, a zero-area triangle, an empty column range,
// a load that replaces a live walk and a full walk. Randomized walks on small
// triangles follow, mixed with huge boxes cut short and degenerate shapes,
// under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
    import tbr_pkg::*;

    localparam int     COORD_WIDTH = 16;
    localparam int     FRAC_BITS   = 4;
    localparam longint FX_ONE      = longint'(1) << FRAC_BITS;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     TAIL_CYCLES = 20;
    localparam int     MAX_REPORTS = 10;

    // one load payload: three vertices and a fill colour
    typedef struct {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic [31:0]                   paint;
    } tri_t;

    // one emitted point
    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic        cov;
        logic [31:0] shade;
        logic        last;
    } pixel_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          item_valid   = 1'b0;
    logic                          item_ready;
    logic                          func         = FUNC_STEP;
    logic signed [COORD_WIDTH-1:0] ax           = '0;
    logic signed [COORD_WIDTH-1:0] ay           = '0;
    logic signed [COORD_WIDTH-1:0] bx           = '0;
    logic signed [COORD_WIDTH-1:0] by           = '0;
    logic signed [COORD_WIDTH-1:0] cx           = '0;
    logic signed [COORD_WIDTH-1:0] cy           = '0;
    logic [31:0]                   paint        = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic signed [11:0]            pix_x;
    logic signed [11:0]            pix_y;
    logic                          covered;
    logic [31:0]                   shade;
    logic                          last;

    // idle percentages per cycle for the sender and the receiver
    int send_idle_pct = 6;
    int recv_idle_pct = 58;

    // scan model state
    longint va_x, va_y, vb_x, vb_y, vc_x, vc_y;
    longint twice_area  = 0;
    longint scan_col    = 0;
    longint scan_row    = 0;
    longint row_col0    = 0;
    longint col_limit   = 0;
    longint row_limit   = 0;
    logic [31:0] fill_word = '0;
    bit     walk_active = 1'b0;

    pixel_t pending_pixels[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int loads_sent     = 0;
    int points_checked = 0;
    int inside_count   = 0;
    int box_ends       = 0;

    triangle_bbox_rasterizer uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points still pending",
                     cycle_count, pending_pixels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls, changed on the falling edge
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic longint min3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Scan model: updates state for one accepted transfer, returns 1 with the
    // expected point when the transfer emits one.
    function automatic bit scan_point(input logic f, input tri_t t, output pixel_t p);
        longint pt_x, pt_y, k_num, l_num, r_num, row_int;
        bit     pt_inside, col_end, row_end;
        p = '0;
        if (f == FUNC_LOAD)
        begin
            va_x = t.ax;
            va_y = t.ay;
            vb_x = t.bx;
            vb_y = t.by;
            vc_x = t.cx;
            vc_y = t.cy;
            twice_area = -vb_y * vc_x + va_y * (vc_x - vb_x) + va_x * (vb_y - vc_y)
                         + vb_x * vc_y;
            // division truncates toward zero, as the column start needs
            row_col0    = min3(va_x, vb_x, vc_x) / FX_ONE;
            col_limit   = max3(va_x, vb_x, vc_x);
            scan_row    = min3(va_y, vb_y, vc_y);
            row_limit   = max3(va_y, vb_y, vc_y);
            scan_col    = row_col0;
            fill_word   = t.paint;
            // negative fractional xmin with no whole column: stays idle
            walk_active = (row_col0 * FX_ONE <= col_limit);
            return 1'b0;
        end
        if (!walk_active)
            return 1'b0;

        pt_x  = scan_col * FX_ONE;
        pt_y  = scan_row;
        k_num = va_y * vc_x - va_x * vc_y + (vc_y - va_y) * pt_x + (va_x - vc_x) * pt_y;
        l_num = va_x * vb_y - va_y * vb_x + (va_y - vb_y) * pt_x + (vb_x - va_x) * pt_y;
        r_num = twice_area - k_num - l_num;
        // sign test against the area instead of a division
        if (twice_area > 0)
            pt_inside = (k_num > 0) && (l_num > 0) && (r_num > 0);
        else if (twice_area < 0)
            pt_inside = (k_num < 0) && (l_num < 0) && (r_num < 0);
        else
            pt_inside = 1'b0;

        col_end = (scan_col + 1) * FX_ONE > col_limit;
        row_end = scan_row + FX_ONE > row_limit;
        row_int = scan_row / FX_ONE;

        p.px    = scan_col[11:0];
        p.py    = row_int[11:0];
        p.cov   = pt_inside;
        p.shade = fill_word;
        p.last  = col_end && row_end;

        if (p.last)
        begin
            walk_active = 1'b0;
        end
        else if (!col_end)
        begin
            scan_col++;
        end
        else
        begin
            scan_col = row_col0;
            scan_row += FX_ONE;
        end
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // result checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                flag_error($sformatf("unexpected point x=%0d y=%0d", pix_x, pix_y));
            end
            else
            begin
                want = pending_pixels.pop_front();
                points_checked++;
                if (covered === 1'b1)
                    inside_count++;
                if (last === 1'b1)
                    box_ends++;
                if (pix_x !== want.px || pix_y !== want.py || covered !== want.cov ||
                    shade !== want.shade || last !== want.last)
                begin
                    flag_error({
                        $sformatf("point exp x=%0d y=%0d cov=%0b shade=%h last=%0b",
                                  $signed(want.px), $signed(want.py), want.cov,
                                  want.shade, want.last),
                        $sformatf(", got x=%0d y=%0d cov=%0b shade=%h last=%0b",
                                  pix_x, pix_y, covered, shade, last)});
                end
            end
        end
    end

    function automatic tri_t make_tri(input int x0, input int y0, input int x1,
                                      input int y1, input int x2, input int y2,
                                      input logic [31:0] colour);
        tri_t t;
        t.ax    = COORD_WIDTH'(x0);
        t.ay    = COORD_WIDTH'(y0);
        t.bx    = COORD_WIDTH'(x1);
        t.by    = COORD_WIDTH'(y1);
        t.cx    = COORD_WIDTH'(x2);
        t.cy    = COORD_WIDTH'(y2);
        t.paint = colour;
        return t;
    endfunction

    // fully random payload: junk on steps, a huge box on loads
    function automatic tri_t random_payload();
        tri_t t;
        t.ax    = COORD_WIDTH'($urandom);
        t.ay    = COORD_WIDTH'($urandom);
        t.bx    = COORD_WIDTH'($urandom);
        t.by    = COORD_WIDTH'($urandom);
        t.cx    = COORD_WIDTH'($urandom);
        t.cy    = COORD_WIDTH'($urandom);
        t.paint = $urandom;
        return t;
    endfunction

    // small triangle anywhere on the plane, box of at most 5 columns by 4 rows
    function automatic tri_t small_triangle();
        tri_t t;
        int   base_x, base_y, dx, dy, kind;
        base_x = int'($urandom_range(65535 - 64)) - 32768;
        base_y = int'($urandom_range(65535 - 64)) - 32768;
        kind   = $urandom_range(9);
        t = make_tri(base_x + $urandom_range(63), base_y + $urandom_range(63),
                     base_x + $urandom_range(63), base_y + $urandom_range(63),
                     base_x + $urandom_range(63), base_y + $urandom_range(63), $urandom);
        if (kind == 0)
        begin
            // repeated vertex, zero area
            t.cx = t.bx;
            t.cy = t.by;
        end
        else if (kind == 1)
        begin
            // collinear, zero area
            dx   = $urandom_range(31);
            dy   = $urandom_range(31);
            t.bx = COORD_WIDTH'(base_x + dx);
            t.by = COORD_WIDTH'(base_y + dy);
            t.cx = COORD_WIDTH'(base_x + 2 * dx);
            t.cy = COORD_WIDTH'(base_y + 2 * dy);
            t.ax = COORD_WIDTH'(base_x);
            t.ay = COORD_WIDTH'(base_y);
        end
        else if (kind == 2)
        begin
            // x straddling the first negative unit, often no whole column
            t.ax = COORD_WIDTH'(-1 - int'($urandom_range(14)));
            t.bx = COORD_WIDTH'(-1 - int'($urandom_range(14)));
            t.cx = COORD_WIDTH'(-int'($urandom_range(20)));
        end
        return t;
    endfunction

    // one transfer; the expectation is taken at the accepting edge
    task automatic send_item(input logic f, input tri_t t);
        pixel_t p;
        bit     emits;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        func       = f;
        ax         = t.ax;
        ay         = t.ay;
        bx         = t.bx;
        by         = t.by;
        cx         = t.cx;
        cy         = t.cy;
        paint      = t.paint;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        emits = scan_point(f, t, p);
        if (emits)
            pending_pixels.push_back(p);
        if (f == FUNC_LOAD)
            loads_sent++;
        items_sent++;
    endtask

    task automatic send_step();
        send_item(FUNC_STEP, random_payload());
    endtask

    // sender holds off until every queued point has come back
    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_idle_steps();
        // no triangle after reset: steps are dropped
        send_step();
        send_step();
    endtask

    task automatic test_extreme_corners();
        // top-right corner of the coordinate range
        send_item(FUNC_LOAD, make_tri(32767, 32767, 32700, 32767, 32767, 32700,
                                      32'hFFFF_FFFF));
        repeat (4) send_step();
        // bottom-left corner, opposite winding; load replaces the live walk
        send_item(FUNC_LOAD, make_tri(-32768, -32768, -32768, -32700, -32700, -32768,
                                      32'h0000_0000));
        repeat (4) send_step();
        // largest possible box, cut short by the next load
        send_item(FUNC_LOAD, make_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                                      32'hA5A5_5A5A));
        repeat (3) send_step();
    endtask

    task automatic test_degenerate();
        // single-point box with zero area; the extra step finds the block idle
        send_item(FUNC_LOAD, make_tri(100, 100, 100, 100, 100, 100, 32'h1234_5678));
        repeat (2) send_step();
        // xmin rounds up to zero, above xmax: no columns at all
        send_item(FUNC_LOAD, make_tri(-15, -3, -1, -3, -8, -10, 32'h8765_4321));
        send_step();
    endtask

    task automatic test_full_walk();
        int n;
        n = 0;
        send_item(FUNC_LOAD, make_tri(0, 0, 40, 8, 8, 40, 32'hC0DE_0001));
        while (walk_active)
        begin
            send_step();
            n++;
            if (n == 3)
                wait_drained();
        end
    endtask

    task automatic test_random_walks(input int quota);
        tri_t t;
        int   start, stop_at, n;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(9) == 0)
            begin
                t       = random_payload();
                stop_at = $urandom_range(1, 8);
            end
            else
            begin
                t       = small_triangle();
                stop_at = ($urandom_range(5) == 0) ? $urandom_range(1, 6) : 1 << 30;
            end
            send_item(FUNC_LOAD, t);
            n = 0;
            while (walk_active && n < stop_at)
            begin
                send_step();
                n++;
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            repeat ($urandom_range(2)) send_step();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 58;
        test_idle_steps();
        test_extreme_corners();
        test_degenerate();
        test_full_walk();

        test_random_walks(275);
        send_idle_pct = 58;
        recv_idle_pct = 6;
        test_random_walks(275);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_walks(275);

        @(negedge clk);
        item_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            flag_error($sformatf("%0d points never arrived", pending_pixels.size()));

        $display("Sent %0d transfers (%0d triangle loads) in %0d cycles.",
                 items_sent, loads_sent, cycle_count);
        $display("Checked %0d points: %0d inside, %0d box ends, %0d errors.",
                 points_checked, inside_count, box_ends, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
